@@ sv/tlf_pkg.sv @@
// Shared types and constants for the text line folder.
package tlf_pkg;

    localparam int FOLD_W     = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [FOLD_W-1:0] FOLD_RESET = 6'd10;
    localparam logic [FOLD_W-1:0] FOLD_MIN   = 6'd2;

    localparam logic [APB_ADDR_W-3:0] REG_FOLD = 1'b0;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_BLANK = 8'd32;

    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       last;
    } out_req_t;

endpackage

@@ sv/tlf_store.sv @@
// Line buffer memory with one write port and one registered read port.
module tlf_store #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         mem_we,
    input  logic [$clog2(MAX_WIDTH)-1:0] mem_waddr,
    input  logic [7:0]                   mem_wdata,
    input  logic [$clog2(MAX_WIDTH)-1:0] mem_raddr,
    output logic [7:0]                   mem_rdata
);

    logic [7:0] mem [MAX_WIDTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[mem_raddr];
    end

    assign mem_rdata = rdata_reg;

endmodule

@@ sv/tlf_outreg.sv @@
// Output register that holds one result byte until the consumer takes it.
module tlf_outreg (
    input  logic               aclk,
    input  logic               aresetn,
    input  tlf_pkg::out_req_t  out_req,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_is_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       last_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_req.load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_req.load) begin
            char_reg <= out_req.data;
            last_reg <= out_req.last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_char = char_reg;
    assign m_is_last  = last_reg;

endmodule

@@ sv/tlf_seq.sv @@
// Sequencer that expands tabs, searches for a break, emits and shifts the line.
module tlf_seq #(
    parameter int MAX_WIDTH = 32,
    parameter int TAB_STOP  = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_in_char,
    input  logic [tlf_pkg::FOLD_W-1:0]   fold_column,
    input  logic                         pos_clear,
    input  logic                         out_free,
    output tlf_pkg::out_req_t            out_req,
    output logic                         mem_we,
    output logic [$clog2(MAX_WIDTH)-1:0] mem_waddr,
    output logic [7:0]                   mem_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0] mem_raddr,
    input  logic [7:0]                   mem_rdata
);

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int MW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam logic [MW-1:0] MOD_LAST = MW'(TAB_STOP - 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_TAB      = 9'b000000010,
        ST_SRCH_RD  = 9'b000000100,
        ST_SRCH_CHK = 9'b000001000,
        ST_EMIT_RD  = 9'b000010000,
        ST_EMIT_WR  = 9'b000100000,
        ST_EMIT_NL  = 9'b001000000,
        ST_SHIFT_RD = 9'b010000000,
        ST_SHIFT_WR = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [MW-1:0] mod_reg, mod_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          shift_reg, shift_next;

    logic [PW-1:0] fold_eff;
    logic [PW-1:0] start_pos;
    logic [MW-1:0] start_mod;
    logic [PW-1:0] start_inc;
    logic          start_zero;

    function automatic logic [MW-1:0] mod_inc(input logic [MW-1:0] m);
        return (m == MOD_LAST) ? '0 : MW'(m + 1'b1);
    endfunction

    always_comb begin
        if (fold_column < tlf_pkg::FOLD_MIN) begin
            fold_eff = PW'(2);
        end else if ({1'b0, fold_column} > 7'(MAX_WIDTH)) begin
            fold_eff = PW'(MAX_WIDTH);
        end else begin
            fold_eff = PW'(fold_column);
        end
    end

    assign start_zero = pos_clear || (pos_reg >= fold_eff);
    assign start_pos  = start_zero ? '0 : pos_reg;
    assign start_mod  = start_zero ? '0 : mod_reg;
    assign start_inc  = PW'(start_pos + 1'b1);
    assign s_ready    = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        mod_next   = mod_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg[AW-1:0];
        mem_wdata  = s_in_char;
        mem_raddr  = idx_reg[AW-1:0];
        out_req    = '{load: 1'b0, data: mem_rdata, last: 1'b0};
        unique case (state_reg)
            ST_IDLE: begin
                if (pos_clear) begin
                    pos_next = '0;
                    mod_next = '0;
                end
                if (s_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = start_pos[AW-1:0];
                    if (s_in_char == tlf_pkg::CH_TAB) begin
                        mem_wdata  = tlf_pkg::CH_BLANK;
                        pos_next   = start_inc;
                        mod_next   = mod_inc(start_mod);
                        state_next = ST_TAB;
                    end else if (s_in_char == tlf_pkg::CH_NL) begin
                        pos_next = start_pos;
                        mod_next = start_mod;
                        if (start_pos != '0) begin
                            cnt_next   = start_pos;
                            idx_next   = '0;
                            shift_next = 1'b0;
                            state_next = ST_EMIT_RD;
                        end
                    end else begin
                        pos_next = start_inc;
                        mod_next = mod_inc(start_mod);
                        if (start_inc >= fold_eff) begin
                            idx_next   = PW'(fold_eff - 1'b1);
                            state_next = ST_SRCH_RD;
                        end
                    end
                end
            end
            ST_TAB: begin
                if (pos_reg >= fold_eff) begin
                    cnt_next   = fold_eff;
                    idx_next   = '0;
                    shift_next = 1'b0;
                    state_next = ST_EMIT_RD;
                end else if (mod_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = tlf_pkg::CH_BLANK;
                    pos_next  = PW'(pos_reg + 1'b1);
                    mod_next  = mod_inc(mod_reg);
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                if (mem_rdata == tlf_pkg::CH_BLANK) begin
                    cnt_next   = PW'(idx_reg + 1'b1);
                    shift_next = (PW'(idx_reg + 1'b1) != fold_eff);
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else if (idx_reg == PW'(1)) begin
                    cnt_next   = fold_eff;
                    shift_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    idx_next   = PW'(idx_reg - 1'b1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    out_req.load = 1'b1;
                    idx_next     = PW'(idx_reg + 1'b1);
                    state_next   = (PW'(idx_reg + 1'b1) == cnt_reg) ? ST_EMIT_NL : ST_EMIT_RD;
                end
            end
            ST_EMIT_NL: begin
                if (out_free) begin
                    out_req    = '{load: 1'b1, data: tlf_pkg::CH_NL, last: 1'b1};
                    pos_next   = '0;
                    mod_next   = '0;
                    idx_next   = cnt_reg;
                    state_next = shift_reg ? ST_SHIFT_RD : ST_IDLE;
                end
            end
            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                mem_we     = 1'b1;
                mem_wdata  = mem_rdata;
                pos_next   = PW'(pos_reg + 1'b1);
                mod_next   = mod_inc(mod_reg);
                idx_next   = PW'(idx_reg + 1'b1);
                state_next = (PW'(idx_reg + 1'b1) == fold_eff) ? ST_IDLE : ST_SHIFT_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            mod_reg   <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            shift_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            mod_reg   <= mod_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_req.load |-> out_free)
        else $error("Result loaded while the output register is occupied.");

    a_idle_pos_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (pos_reg < fold_eff))
        else $error("Fill position reached the fold column while idle.");

    a_shift_src_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT_WR) |-> (idx_reg < fold_eff && pos_reg < idx_reg))
        else $error("Shift source index is out of the line.");

endmodule

@@ sv/text_line_folder.sv @@
// Top level: an ordinary byte that does not fill the line is taken in ST_IDLE; a tab writes its
// first blank there and each further blank in ST_TAB. A fold reads and checks each searched
// position, reads and writes each emitted byte, sends the newline and reads and writes each
// moved byte, and waits for m_ready while the output register is full. The buffer read is registered.
// The output register lets the next byte be accepted while the last result still waits.
// Synchronous active-low reset clears the fill position and output valid, not the line buffer.
module text_line_folder #(
    parameter int MAX_WIDTH = 32,
    parameter int TAB_STOP  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_char,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_char,
    output logic                             m_is_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tlf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tlf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [tlf_pkg::FOLD_W-1:0] fold_reg, fold_next;
    logic                       fold_wr;
    logic                       out_free;
    tlf_pkg::out_req_t          out_req;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [7:0]                 mem_wdata;
    logic [AW-1:0]              mem_raddr;
    logic [7:0]                 mem_rdata;

    assign pready  = 1'b1;
    assign fold_wr = psel && penable && pwrite &&
                     (paddr[tlf_pkg::APB_ADDR_W-1:2] == tlf_pkg::REG_FOLD);
    assign fold_next = fold_wr ? pwdata[tlf_pkg::FOLD_W-1:0] : fold_reg;
    assign prdata = (paddr[tlf_pkg::APB_ADDR_W-1:2] == tlf_pkg::REG_FOLD) ?
                    tlf_pkg::APB_DATA_W'(fold_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_reg <= tlf_pkg::FOLD_RESET;
        end else begin
            fold_reg <= fold_next;
        end
    end

    tlf_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .TAB_STOP  (TAB_STOP)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .fold_column (fold_reg),
        .pos_clear   (fold_wr),
        .out_free    (out_free),
        .out_req     (out_req),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    tlf_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .aclk      (aclk),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tlf_outreg u_outreg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .out_req    (out_req),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_is_last  (m_is_last)
    );

endmodule

@@ test/text_line_folder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text line folder with a scoreboard class and random text.

typedef struct {
    logic [7:0] ch;
    logic       last;
} folded_byte_t;

class fold_scoreboard #(int LINE_MAX = 32, int TAB_WIDTH = 8);
    logic [7:0]   line_buf [LINE_MAX];
    int           line_len;
    logic [5:0]   fold_reg;
    folded_byte_t folded_q [$];
    int           fail_count;

    function new();
        line_len   = 0;
        fold_reg   = tlf_pkg::FOLD_RESET;
        fail_count = 0;
        foreach (line_buf[i]) line_buf[i] = 8'd0;
    endfunction

    function void write_fold(logic [5:0] value);
        fold_reg = value;
        line_len = 0;
    endfunction

    function int open_count();
        return folded_q.size();
    endfunction

    function void push_line(int count);
        folded_byte_t b;
        if (count == 0) return;
        if (count > LINE_MAX) count = LINE_MAX;
        b.last = 1'b0;
        for (int i = 0; i < count; i++) begin
            b.ch = line_buf[i];
            folded_q.push_back(b);
        end
        b.ch = tlf_pkg::CH_NL;
        folded_q.push_back(b);
    endfunction

    function void note_request(logic [7:0] c);
        int f;
        int pos;
        int k;
        int cut;
        int moved;
        int before_size;
        folded_byte_t b;
        f = fold_reg;
        if (f < 2) f = 2;
        if (f > LINE_MAX) f = LINE_MAX;
        pos = line_len;
        if (pos >= f) pos = 0;
        before_size = folded_q.size();
        line_buf[pos] = c;
        if (c == tlf_pkg::CH_TAB) begin
            line_buf[pos] = tlf_pkg::CH_BLANK;
            pos++;
            while (pos < f && (pos % TAB_WIDTH) != 0) begin
                line_buf[pos] = tlf_pkg::CH_BLANK;
                pos++;
            end
            if (pos >= f) begin
                push_line(f);
                pos = 0;
            end
        end else if (c == tlf_pkg::CH_NL) begin
            push_line(pos);
            pos = 0;
        end else begin
            pos++;
            if (pos >= f) begin
                k = f - 1;
                while (k > 0 && line_buf[k] != tlf_pkg::CH_BLANK) k--;
                cut = (k == 0) ? f : k + 1;
                push_line(cut);
                if (cut >= f) begin
                    pos = 0;
                end else begin
                    moved = 0;
                    for (int j = cut; j < f; j++) begin
                        line_buf[moved] = line_buf[j];
                        moved++;
                    end
                    pos = moved;
                end
            end
        end
        line_len = pos;
        if (folded_q.size() > before_size) begin
            b = folded_q.pop_back();
            b.last = 1'b1;
            folded_q.push_back(b);
        end
    endfunction

    function void check_result(logic [7:0] ch, logic last);
        folded_byte_t want;
        if (folded_q.size() == 0) begin
            $display("%0t: unexpected result out_char %h is_last %b", $time, ch, last);
            fail_count++;
            return;
        end
        want = folded_q.pop_front();
        if (ch !== want.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
            fail_count++;
        end
        if (last !== want.last) begin
            $display("%0t: is_last expected %b actual %b", $time, want.last, last);
            fail_count++;
        end
    endfunction
endclass

module text_line_folder_tb;

    localparam int LINE_MAX      = 32;
    localparam int TAB_WIDTH     = 8;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 35;

    localparam logic [tlf_pkg::APB_ADDR_W-1:0] ADDR_FOLD  = {tlf_pkg::REG_FOLD, 2'b00};
    localparam logic [tlf_pkg::APB_ADDR_W-1:0] ADDR_SPARE = 3'd4;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_in_char;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [7:0]                     m_out_char;
    logic                           m_is_last;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tlf_pkg::APB_ADDR_W-1:0] paddr;
    logic [tlf_pkg::APB_DATA_W-1:0] pwdata;
    logic [tlf_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    fold_scoreboard #(LINE_MAX, TAB_WIDTH) sb;
    bit          gaps_on;
    int unsigned cycle_count = 0;

    logic [7:0] warmup_text [19] = '{8'h00, 8'hFF, tlf_pkg::CH_NL, tlf_pkg::CH_NL,
                                     tlf_pkg::CH_TAB, "a", "b", tlf_pkg::CH_TAB,
                                     tlf_pkg::CH_TAB, "a", "b", "c", "d", "e", "f", "g", "h",
                                     "i", "j"};
    logic [7:0] narrow_text [5] = '{tlf_pkg::CH_BLANK, "x", "x", tlf_pkg::CH_BLANK,
                                    tlf_pkg::CH_TAB};
    logic [5:0] fold_plan [PHASES] = '{6'd1, 6'd63, 6'd32, 6'd2, 6'd33, 6'd10, 6'd7, 6'd16,
                                       6'd0, 6'd0, 6'd0, 6'd40};

    text_line_folder #(
        .MAX_WIDTH(LINE_MAX),
        .TAB_STOP (TAB_WIDTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_char (s_in_char),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_char(m_out_char),
        .m_is_last (m_is_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_out_char, m_is_last);
        end
        m_ready <= gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
    end

    function automatic logic [7:0] pick_char();
        int unsigned r;
        logic [7:0]  c;
        r = $urandom_range(0, 99);
        if (r < 55) c = 8'($urandom_range(97, 122));
        else if (r < 72) c = tlf_pkg::CH_BLANK;
        else if (r < 78) c = tlf_pkg::CH_TAB;
        else if (r < 85) c = tlf_pkg::CH_NL;
        else c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (gaps_on && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 29) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(c);
    endtask

    task automatic apb_write(input logic [tlf_pkg::APB_ADDR_W-1:0] addr,
                             input logic [tlf_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [tlf_pkg::APB_ADDR_W-1:0] addr,
                            output logic [tlf_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_fold(input logic [5:0] value);
        logic [tlf_pkg::APB_DATA_W-1:0] rd;
        apb_write(ADDR_FOLD, tlf_pkg::APB_DATA_W'(value));
        sb.write_fold(value);
        apb_read(ADDR_FOLD, rd);
        if (rd[tlf_pkg::FOLD_W-1:0] !== value) begin
            $display("%0t: fold_column readback expected %h actual %h", $time, value,
                     rd[tlf_pkg::FOLD_W-1:0]);
            sb.fail_count++;
        end
    endtask

    // The line may still be shifting after its last byte left, so settle before going idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.open_count() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        sb          = new();
        gaps_on     = 1'b1;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_in_char   = 8'd0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (warmup_text[i]) send_char(warmup_text[i]);
        drain();
        set_fold(6'd0);
        foreach (narrow_text[i]) send_char(narrow_text[i]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p != 2);
            if (p == 5) apb_write(ADDR_SPARE, $urandom);
            set_fold((p >= 8 && p <= 10) ? 6'($urandom_range(0, 63)) : fold_plan[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) send_char(pick_char());
            drain();
        end

        if (sb.fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/tlf_pkg.sv
sv/tlf_store.sv
sv/tlf_outreg.sv
sv/tlf_seq.sv
sv/text_line_folder.sv
test/text_line_folder_tb.sv
